@@ rtl/grpe_pkg.sv @@
// Package with shared types, constants and byte tables of the report engine.
`timescale 1ns / 1ps
package grpe_pkg;

	localparam int REPORT_BYTES_DEF = 48;
	localparam int MAX_READ_BYTES_DEF = 29;

	localparam logic [1:0] KIND_SET = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_SUB = 2'd2;
	localparam logic [1:0] KIND_CONNECT = 2'd3;

	localparam logic [2:0] REG_PROFILE = 3'd0;
	localparam logic [2:0] REG_DIR_MODE = 3'd1;
	localparam logic [2:0] REG_BATTERY = 3'd2;
	localparam logic [2:0] REG_ADDRESS = 3'd3;
	localparam logic [2:0] REG_KEEPALIVE = 3'd4;

	localparam logic [7:0] ID_FULL = 8'h30;
	localparam logic [7:0] ID_SIMPLE = 8'h3F;
	localparam logic [7:0] ID_REPLY = 8'h21;

	localparam logic [7:0] SUB_INFO = 8'h02;
	localparam logic [7:0] SUB_MODE = 8'h03;
	localparam logic [7:0] SUB_ELAPSED = 8'h04;
	localparam logic [7:0] SUB_READ = 8'h10;

	localparam logic [7:0] ACK_PLAIN = 8'h80;
	localparam logic [7:0] ACK_INFO = 8'h82;
	localparam logic [7:0] ACK_ELAPSED = 8'h83;
	localparam logic [7:0] ACK_READ = 8'h90;

	localparam logic [31:0] ADDR_CAL_A = 32'h603D;
	localparam logic [31:0] ADDR_CAL_B = 32'h6080;
	localparam logic [31:0] ADDR_CAL_C = 32'h6098;
	localparam logic [31:0] ADDR_ONES_A = 32'h8010;
	localparam logic [31:0] ADDR_ONES_B = 32'h8028;

	localparam logic [11:0] AXIS_HIGH = 12'd3500;
	localparam logic [11:0] AXIS_LOW = 12'd600;
	localparam logic [11:0] AXIS_MID = 12'd2048;

	typedef enum logic [1:0] {
		JOB_FULL,
		JOB_SIMPLE,
		JOB_REPLY
	} job_kind_t;

	typedef enum logic [1:0] {
		ROM_NONE,
		ROM_A,
		ROM_B,
		ROM_C
	} rom_sel_t;

	// One queued job: everything the byte generator needs to form a report.
	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  counter;
		logic [7:0]  btn0;
		logic [7:0]  btn1;
		logic [7:0]  btn2;
		logic [23:0] lstick;
		logic [7:0]  sbtn0;
		logic [7:0]  hat;
		logic [7:0]  ax_lo;
		logic [7:0]  ax_hi;
		logic [7:0]  ay_lo;
		logic [7:0]  ay_hi;
		logic [7:0]  sub_id;
		logic [7:0]  ack;
		logic [39:0] args;
		logic [5:0]  read_size;
		rom_sel_t    rom;
		logic        ones;
		logic [47:0] address;
		logic [7:0]  battery;
	} job_t;

	function automatic logic [7:0] cal_a_byte(input logic [5:0] k);
		logic [7:0] v;
		case (k)
			6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15: v = 8'hF0;
			6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16: v = 8'h07;
			6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17: v = 8'h7F;
			6'd18, 6'd19: v = 8'h0F;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] cal_c_byte(input logic [5:0] k);
		logic [7:0] v;
		case (k)
			6'd0: v = 8'h19;
			6'd1: v = 8'hd0;
			6'd2: v = 8'h4c;
			6'd3: v = 8'hae;
			6'd4: v = 8'h40;
			6'd5: v = 8'he1;
			6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17: v = 8'hff;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] cal_b_byte(input logic [5:0] k);
		logic [7:0] v;
		case (k)
			6'd0: v = 8'h5e;
			6'd1: v = 8'h01;
			6'd4: v = 8'hf1;
			6'd5: v = 8'h0f;
			default: v = (k >= 6'd6 && k < 6'd24) ? cal_c_byte(k - 6'd6) : 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] elapsed_byte(input logic [3:0] k);
		logic [7:0] v;
		case (k)
			4'd1: v = 8'h6a;
			4'd2, 4'd4, 4'd6, 4'd8: v = 8'h01;
			4'd3: v = 8'hbb;
			4'd5: v = 8'h93;
			4'd7: v = 8'h95;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/grpe_front.sv @@
// Front part: takes input words, keeps controller state and builds report jobs.
`timescale 1ns / 1ps
module grpe_front #(
	parameter int MAX_READ_BYTES = grpe_pkg::MAX_READ_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        buttons,
	input  logic [31:0]       now_ms,
	input  logic [6:0]        sub_length,
	input  logic [7:0]        sub_id,
	input  logic [39:0]       sub_args,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [47:0]       cfg_data,
	output logic              job_valid,
	input  logic              job_ready,
	output grpe_pkg::job_t    job
);

	logic        profile_q;
	logic [1:0]  dir_mode_q;
	logic [6:0]  battery_q;
	logic [47:0] address_q;
	logic [9:0]  keepalive_q;
	logic [7:0]  held_q;
	logic [7:0]  counter_q;
	logic        full_q;
	logic [23:0] last_btn_q;
	logic [31:0] last_time_q;

	logic        use_pad, use_stick;
	logic        a, b, up, dn, lf, rt;
	logic [7:0]  btn0, btn1, btn2, sbtn0, hat;
	logic [11:0] lx, ly;
	logic [7:0]  battery_byte;
	logic [31:0] elapsed;
	logic        send_simple;
	logic        take;
	logic        need_job;
	logic [7:0]  read_raw;
	logic [5:0]  read_size;
	logic [1:0]  v_i, h_i;
	grpe_pkg::job_t job_c;

	assign a = held_q[0];
	assign b = held_q[1];
	assign up = held_q[4];
	assign dn = held_q[5];
	assign lf = held_q[6];
	assign rt = held_q[7];
	assign use_pad = (dir_mode_q != 2'd1);
	assign use_stick = (dir_mode_q == 2'd1) || (dir_mode_q == 2'd2);

	always_comb begin
		btn0 = profile_q ? {5'd0, a, 1'b0, b} : {4'd0, a, b, 2'd0};
		btn1 = {6'd0, held_q[3], held_q[2]};
		btn2 = use_pad ? {4'd0, lf, rt, up, dn} : 8'd0;
		sbtn0 = profile_q ? {5'd0, b, 1'b0, a} : {6'd0, a, b};
		lx = grpe_pkg::AXIS_MID;
		ly = grpe_pkg::AXIS_MID;
		if (use_stick && rt && !lf) lx = grpe_pkg::AXIS_HIGH;
		if (use_stick && lf && !rt) lx = grpe_pkg::AXIS_LOW;
		if (use_stick && up && !dn) ly = grpe_pkg::AXIS_HIGH;
		if (use_stick && dn && !up) ly = grpe_pkg::AXIS_LOW;
		v_i = 2'd1 + {1'b0, use_pad && up} - {1'b0, use_pad && dn};
		h_i = 2'd1 + {1'b0, use_pad && rt} - {1'b0, use_pad && lf};
		case ({v_i, h_i})
			4'b00_00: hat = 8'd5;
			4'b00_01: hat = 8'd4;
			4'b00_10: hat = 8'd3;
			4'b01_00: hat = 8'd6;
			4'b01_01: hat = 8'd8;
			4'b01_10: hat = 8'd2;
			4'b10_00: hat = 8'd7;
			4'b10_01: hat = 8'd0;
			4'b10_10: hat = 8'd1;
			default: hat = 8'd8;
		endcase
		if (battery_q >= 7'd70) battery_byte = 8'h80;
		else if (battery_q >= 7'd40) battery_byte = 8'h60;
		else if (battery_q >= 7'd20) battery_byte = 8'h40;
		else if (battery_q >= 7'd10) battery_byte = 8'h20;
		else battery_byte = 8'h00;
	end

	assign elapsed = now_ms - last_time_q;
	assign send_simple = ({btn2, btn1, btn0} != last_btn_q) || (elapsed >= {22'd0, keepalive_q})
		? 1'b1 : 1'b0;
	assign read_raw = sub_args[39:32];
	assign read_size = (read_raw > 8'(MAX_READ_BYTES)) ? 6'(MAX_READ_BYTES) : read_raw[5:0];

	always_comb begin
		job_c = '0;
		job_c.counter = counter_q;
		job_c.battery = battery_byte;
		job_c.args = sub_args;
		job_c.sub_id = sub_id;
		job_c.address = address_q;
		job_c.read_size = read_size;
		job_c.lstick = {ly[11:4], ly[3:0], lx[11:8], lx[7:0]};
		job_c.btn0 = btn0;
		job_c.btn1 = btn1;
		job_c.btn2 = btn2;
		job_c.sbtn0 = sbtn0;
		job_c.hat = hat;
		job_c.ax_lo = (use_stick && rt && !lf) ? 8'hFF : 8'h00;
		job_c.ax_hi = (use_stick && rt && !lf) ? 8'hFF : ((use_stick && lf && !rt) ? 8'h00 : 8'h80);
		job_c.ay_lo = (use_stick && dn && !up) ? 8'hFF : 8'h00;
		job_c.ay_hi = (use_stick && dn && !up) ? 8'hFF : ((use_stick && up && !dn) ? 8'h00 : 8'h80);
		job_c.rom = grpe_pkg::ROM_NONE;
		job_c.ones = 1'b0;
		if (sub_args[31:0] == grpe_pkg::ADDR_CAL_A) job_c.rom = grpe_pkg::ROM_A;
		else if (sub_args[31:0] == grpe_pkg::ADDR_CAL_B) job_c.rom = grpe_pkg::ROM_B;
		else if (sub_args[31:0] == grpe_pkg::ADDR_CAL_C) job_c.rom = grpe_pkg::ROM_C;
		else if (sub_args[31:0] == grpe_pkg::ADDR_ONES_A || sub_args[31:0] == grpe_pkg::ADDR_ONES_B)
			job_c.ones = 1'b1;
		case (sub_id)
			grpe_pkg::SUB_INFO: job_c.ack = grpe_pkg::ACK_INFO;
			grpe_pkg::SUB_READ: job_c.ack = grpe_pkg::ACK_READ;
			grpe_pkg::SUB_ELAPSED: job_c.ack = grpe_pkg::ACK_ELAPSED;
			default: job_c.ack = grpe_pkg::ACK_PLAIN;
		endcase
		if (kind == grpe_pkg::KIND_SUB) job_c.kind = grpe_pkg::JOB_REPLY;
		else if (full_q) job_c.kind = grpe_pkg::JOB_FULL;
		else job_c.kind = grpe_pkg::JOB_SIMPLE;
	end

	always_comb begin
		case (kind)
			grpe_pkg::KIND_TICK: need_job = full_q || send_simple;
			grpe_pkg::KIND_SUB: need_job = (sub_length >= 7'd11);
			default: need_job = 1'b0;
		endcase
	end

	assign in_stall = need_job && !job_ready;
	assign take = in_valid && !in_stall;
	assign job_valid = in_valid && need_job;
	assign job = job_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_q <= 1'b0;
			dir_mode_q <= 2'd0;
			battery_q <= 7'd100;
			address_q <= 48'd0;
			keepalive_q <= 10'd100;
			held_q <= 8'd0;
			counter_q <= 8'd0;
			full_q <= 1'b0;
			last_btn_q <= 24'hFFFFFF;
			last_time_q <= 32'd0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					grpe_pkg::REG_PROFILE: profile_q <= cfg_data[0];
					grpe_pkg::REG_DIR_MODE: dir_mode_q <= cfg_data[1:0];
					grpe_pkg::REG_BATTERY: battery_q <= cfg_data[6:0];
					grpe_pkg::REG_ADDRESS: address_q <= cfg_data;
					grpe_pkg::REG_KEEPALIVE: keepalive_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (take) begin
				case (kind)
					grpe_pkg::KIND_SET: held_q <= buttons;
					grpe_pkg::KIND_CONNECT: full_q <= 1'b0;
					grpe_pkg::KIND_TICK: begin
						if (full_q) begin
							counter_q <= counter_q + 8'd1;
						end else if (send_simple) begin
							last_btn_q <= {btn2, btn1, btn0};
							last_time_q <= now_ms;
						end
					end
					default: begin
						if (sub_length >= 7'd11) begin
							counter_q <= counter_q + 8'd1;
							if (sub_id == grpe_pkg::SUB_MODE)
								full_q <= (sub_args[7:0] != 8'h3F);
						end
					end
				endcase
			end
		end
	end

endmodule

@@ rtl/grpe_queue.sv @@
// Short job queue between the front part and the byte generator.
`timescale 1ns / 1ps
module grpe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  grpe_pkg::job_t wr_job,
	output logic           rd_valid,
	input  logic           rd_ready,
	output grpe_pkg::job_t rd_job
);

	grpe_pkg::job_t slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job = slot_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/grpe_back.sv @@
// Back part: walks a job byte by byte into a registered output word.
`timescale 1ns / 1ps
module grpe_back #(
	parameter int REPORT_BYTES = grpe_pkg::REPORT_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  grpe_pkg::job_t job,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     frame_id,
	output logic [7:0]     data_byte,
	output logic           last
);

	logic [5:0]  idx_q;
	logic [7:0]  byte_c, id_c;
	logic        last_c;
	logic [5:0]  nbytes;
	logic        advance;
	logic [5:0]  p, k;

	assign nbytes = (job.kind == grpe_pkg::JOB_SIMPLE) ? 6'd11 : 6'(REPORT_BYTES);
	assign advance = job_valid && (!out_valid || !out_stall);
	assign last_c = (idx_q == nbytes - 6'd1);
	assign job_ready = advance && last_c;
	assign p = idx_q - 6'd14;
	assign k = idx_q - 6'd19;

	always_comb begin
		byte_c = 8'h00;
		case (job.kind)
			grpe_pkg::JOB_FULL: id_c = grpe_pkg::ID_FULL;
			grpe_pkg::JOB_SIMPLE: id_c = grpe_pkg::ID_SIMPLE;
			default: id_c = grpe_pkg::ID_REPLY;
		endcase
		if (job.kind == grpe_pkg::JOB_SIMPLE) begin
			case (idx_q)
				6'd0: byte_c = job.sbtn0;
				6'd1: byte_c = job.btn1;
				6'd2: byte_c = job.hat;
				6'd3: byte_c = job.ax_lo;
				6'd4: byte_c = job.ax_hi;
				6'd5: byte_c = job.ay_lo;
				6'd6: byte_c = job.ay_hi;
				6'd8, 6'd10: byte_c = 8'h80;
				default: byte_c = 8'h00;
			endcase
		end else begin
			case (idx_q)
				6'd0: byte_c = job.counter;
				6'd1: byte_c = job.battery;
				6'd2: byte_c = (job.kind == grpe_pkg::JOB_FULL) ? job.btn0 : 8'h00;
				6'd3: byte_c = (job.kind == grpe_pkg::JOB_FULL) ? job.btn1 : 8'h00;
				6'd4: byte_c = (job.kind == grpe_pkg::JOB_FULL) ? job.btn2 : 8'h00;
				6'd5: byte_c = (job.kind == grpe_pkg::JOB_FULL) ? job.lstick[7:0] : 8'h00;
				6'd6: byte_c = (job.kind == grpe_pkg::JOB_FULL) ? job.lstick[15:8] : 8'h08;
				6'd7: byte_c = (job.kind == grpe_pkg::JOB_FULL) ? job.lstick[23:16] : 8'h80;
				6'd8: byte_c = 8'h00;
				6'd9: byte_c = 8'h08;
				6'd10, 6'd11: byte_c = 8'h80;
				6'd12: byte_c = (job.kind == grpe_pkg::JOB_REPLY) ? job.ack : 8'h00;
				6'd13: byte_c = (job.kind == grpe_pkg::JOB_REPLY) ? job.sub_id : 8'h00;
				default: begin
					if (job.kind == grpe_pkg::JOB_REPLY) begin
						case (job.sub_id)
							grpe_pkg::SUB_INFO: begin
								case (idx_q)
									6'd14, 6'd16: byte_c = 8'h03;
									6'd15: byte_c = 8'h48;
									6'd17, 6'd25: byte_c = 8'h02;
									6'd18: byte_c = job.address[47:40];
									6'd19: byte_c = job.address[39:32];
									6'd20: byte_c = job.address[31:24];
									6'd21: byte_c = job.address[23:16];
									6'd22: byte_c = job.address[15:8];
									6'd23: byte_c = job.address[7:0];
									6'd24: byte_c = 8'h01;
									default: byte_c = 8'h00;
								endcase
							end
							grpe_pkg::SUB_ELAPSED: begin
								if (idx_q < 6'd23) byte_c = grpe_pkg::elapsed_byte(p[3:0]);
							end
							grpe_pkg::SUB_READ: begin
								if (p < 6'd5) begin
									byte_c = job.args[8*p[2:0] +: 8];
								end else if (k < job.read_size) begin
									if (job.ones) byte_c = 8'hFF;
									else begin
										case (job.rom)
											grpe_pkg::ROM_A: byte_c = grpe_pkg::cal_a_byte(k);
											grpe_pkg::ROM_B: byte_c = grpe_pkg::cal_b_byte(k);
											grpe_pkg::ROM_C: byte_c = grpe_pkg::cal_c_byte(k);
											default: byte_c = 8'h00;
										endcase
									end
								end
							end
							default: byte_c = 8'h00;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_id <= id_c;
			data_byte <= byte_c;
			last <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 6'd0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				out_valid <= 1'b1;
				idx_q <= last_c ? 6'd0 : idx_q + 6'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/gamepad_report_protocol_engine_unit.sv @@
// Top level of the gamepad report protocol engine.
`timescale 1ns / 1ps
// Each accepted input word is classified combinationally by the front part and, if it
// causes a report, queued as a job in a two-entry queue; the back part then sends one
// report byte per cycle while out_stall is low. A full or reply report has REPORT_BYTES
// bytes and a simple report 11. Input words keep flowing while a report drains until the
// queue is full. Configuration writes take effect at once and are always ready.
module gamepad_report_protocol_engine_unit #(
	parameter int REPORT_BYTES = grpe_pkg::REPORT_BYTES_DEF,
	parameter int MAX_READ_BYTES = grpe_pkg::MAX_READ_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  buttons,
	input  logic [31:0] now_ms,
	input  logic [6:0]  sub_length,
	input  logic [7:0]  sub_id,
	input  logic [39:0] sub_args,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_id,
	output logic [7:0]  data_byte,
	output logic        last
);

	logic           fj_valid, fj_ready, bj_valid, bj_ready;
	grpe_pkg::job_t fj, bj;

	assign cfg_ready = 1'b1;

	grpe_front #(.MAX_READ_BYTES(MAX_READ_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .buttons, .now_ms,
		.sub_length, .sub_id, .sub_args, .cfg_valid, .cfg_index, .cfg_data,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	grpe_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
	);

	grpe_back #(.REPORT_BYTES(REPORT_BYTES)) u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.out_valid, .out_stall, .frame_id, .data_byte, .last
	);

endmodule

@@ rtl/grpe_checker.sv @@
// Port-level checker of the report engine, bound to the top level.
`timescale 1ns / 1ps
module grpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_id,
	input logic       last,
	input logic       cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_id))
		else $error("Stalled output word changed.");

	a_id_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_id == grpe_pkg::ID_FULL || frame_id == grpe_pkg::ID_SIMPLE
			|| frame_id == grpe_pkg::ID_REPLY)
		else $error("Unknown report identifier.");

	a_id_within: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last ##1 out_valid |-> $stable(frame_id))
		else $error("Report identifier changed inside a report.");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("Configuration port not ready.");

endmodule

bind gamepad_report_protocol_engine_unit grpe_checker u_grpe_checker (
	.clk, .arst_n, .out_valid, .out_stall, .frame_id, .last, .cfg_ready
);
